// ===== rtl/core/mmt_pkg.sv =====
// Shared types, constants and helpers of the matrix multiply engine.
// No dependencies; the RTL files that use it refer to it by scoped names, the testbench imports it.
package mmt_pkg;

  // Matrix geometry
  localparam int MAX_DIM = 8;
  localparam int IDX_W   = $clog2(MAX_DIM);
  localparam int ADDR_W  = 2 * IDX_W;
  localparam int DIM_W   = 4;

  // Datapath widths
  localparam int ELEM_W = 16;
  localparam int PROD_W = 2 * ELEM_W;
  localparam int OUT_W  = 32;
  localparam int ACC_W  = PROD_W + $clog2(MAX_DIM) + 1;

  // Configuration port
  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_ROWS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_COLS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_LEN = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 2'd3;

  // Request codes
  localparam logic [1:0] REQ_WR_A    = 2'd0;
  localparam logic [1:0] REQ_WR_B    = 2'd1;
  localparam logic [1:0] REQ_COMPUTE = 2'd2;

  // Product selection
  localparam logic [1:0] MODE_AB  = 2'd0;
  localparam logic [1:0] MODE_ABT = 2'd1;
  localparam logic [1:0] MODE_ATB = 2'd2;

  // Saturation limits
  localparam logic signed [OUT_W-1:0] SAT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] SAT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  // Tag that travels with each read of the stores
  typedef struct packed {
    logic             vld;
    logic             first;     // k == 0, restart the sum
    logic             lastk;     // final term of this element
    logic             last_elem; // final element of the matrix
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } mmt_tag_t;

  // Dimension register to last loop index: 0 acts as 1, above MAX_DIM as MAX_DIM
  function automatic logic [IDX_W-1:0] dim_last(input logic [DIM_W-1:0] v);
    logic [IDX_W-1:0] r;
    if (v == '0) begin
      r = '0;
    end else if (v > DIM_W'(MAX_DIM)) begin
      r = IDX_W'(MAX_DIM - 1);
    end else begin
      r = IDX_W'(v - 1'b1);
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/matrix_multiply_transpose.sv =====
// Top level of the matrix multiply engine: config registers, stores, control.
// Depends on mmt_pkg, mmt_ram, mmt_seq and mmt_mac.
//
// Usage:
//   Items enter on start while busy is low. A load item (type 0 or 1) writes
//   one Q8.8 element into store A or B at {elem_row, elem_col}; busy stays
//   low. Type 3 is dropped. A compute item (type 2) raises busy and emits
//   rows*cols results in row-major order, one strobe of out_valid per
//   element, out_last on the final one.
// Timing:
//   One shared multiplier and accumulator take one inner term per cycle.
//   Each term is issued with its store read, then multiplied, then
//   accumulated; the accumulate step also registers the result. Busy drops
//   at the edge that raises the last strobe, so the next item can be
//   accepted at the edge that ends it.
// Config:
//   Written through cfg_we/cfg_index/cfg_wdata, by the user only while idle; the block does not enforce it.
// Reset:
//   Synchronous rst_n clears control state and sets dims 8x8x8, mode 0.
//   Store contents are undefined until written. The receiver cannot stall;
//   each out_valid strobe is high for a single cycle; the data hold until the next result.
module matrix_multiply_transpose (
  input  logic                                clk,
  input  logic                                rst_n,
  // input items
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          in_req_type,
  input  logic [mmt_pkg::IDX_W-1:0]           in_elem_row,
  input  logic [mmt_pkg::IDX_W-1:0]           in_elem_col,
  input  logic signed [mmt_pkg::ELEM_W-1:0]   in_elem_value,
  // results
  output logic                                out_valid,
  output logic [mmt_pkg::IDX_W-1:0]           out_row,
  output logic [mmt_pkg::IDX_W-1:0]           out_col,
  output logic signed [mmt_pkg::OUT_W-1:0]    out_value,
  output logic                                out_last,
  // configuration
  input  logic                                cfg_we,
  input  logic [mmt_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mmt_pkg::CFG_W-1:0]           cfg_wdata
);

  logic [mmt_pkg::DIM_W-1:0]  out_rows_r, out_cols_r, inner_len_r;
  logic [1:0]                 mode_r;
  logic                       busy_r, busy_nxt;
  logic                       accept, go, wr_a, wr_b, done;
  logic [mmt_pkg::ADDR_W-1:0] wr_addr, a_addr, b_addr;
  logic [mmt_pkg::ELEM_W-1:0] a_rdata, b_rdata;
  mmt_pkg::mmt_tag_t          tag_s0, tag_s1_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_rows_r  <= mmt_pkg::DIM_W'(mmt_pkg::MAX_DIM);
      out_cols_r  <= mmt_pkg::DIM_W'(mmt_pkg::MAX_DIM);
      inner_len_r <= mmt_pkg::DIM_W'(mmt_pkg::MAX_DIM);
      mode_r      <= mmt_pkg::MODE_AB;
    end else if (cfg_we) begin
      case (cfg_index)
        mmt_pkg::CFG_OUT_ROWS:  out_rows_r  <= cfg_wdata;
        mmt_pkg::CFG_OUT_COLS:  out_cols_r  <= cfg_wdata;
        mmt_pkg::CFG_INNER_LEN: inner_len_r <= cfg_wdata;
        mmt_pkg::CFG_MODE:      mode_r      <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  // Item decode
  assign accept  = start && !busy_r;
  assign wr_a    = accept && (in_req_type == mmt_pkg::REQ_WR_A);
  assign wr_b    = accept && (in_req_type == mmt_pkg::REQ_WR_B);
  assign go      = accept && (in_req_type == mmt_pkg::REQ_COMPUTE);
  assign wr_addr = {in_elem_row, in_elem_col};

  // Busy from compute accept until the last result strobe
  assign busy_nxt = go ? 1'b1 : (done ? 1'b0 : busy_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      tag_s1_r <= '0;
    end else begin
      busy_r   <= busy_nxt;
      tag_s1_r <= tag_s0;
    end
  end

  assign busy = busy_r;

  // Element stores
  mmt_ram #(.WIDTH(mmt_pkg::ELEM_W), .DEPTH(mmt_pkg::MAX_DIM * mmt_pkg::MAX_DIM)) u_store_a (
    .clk   (clk),
    .we    (wr_a),
    .waddr (wr_addr),
    .wdata (in_elem_value),
    .raddr (a_addr),
    .rdata (a_rdata)
  );

  mmt_ram #(.WIDTH(mmt_pkg::ELEM_W), .DEPTH(mmt_pkg::MAX_DIM * mmt_pkg::MAX_DIM)) u_store_b (
    .clk   (clk),
    .we    (wr_b),
    .waddr (wr_addr),
    .wdata (in_elem_value),
    .raddr (b_addr),
    .rdata (b_rdata)
  );

  // Loop sequencer
  mmt_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .go         (go),
    .rows_last  (mmt_pkg::dim_last(out_rows_r)),
    .cols_last  (mmt_pkg::dim_last(out_cols_r)),
    .inner_last (mmt_pkg::dim_last(inner_len_r)),
    .mode       (mode_r),
    .a_addr     (a_addr),
    .b_addr     (b_addr),
    .tag        (tag_s0)
  );

  // Shared multiply-accumulate
  mmt_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .a_data    (a_rdata),
    .b_data    (b_rdata),
    .tag_in    (tag_s1_r),
    .done      (done),
    .out_valid (out_valid),
    .out_row   (out_row),
    .out_col   (out_col),
    .out_value (out_value),
    .out_last  (out_last)
  );

  // Store reads only happen inside a compute
  a_seq_busy: assert property (@(posedge clk) disable iff (!rst_n)
    tag_s0.vld |-> busy_r)
    else $error("store read while idle");

  // A compute item raises busy
  a_go_busy: assert property (@(posedge clk) disable iff (!rst_n)
    go |=> busy_r)
    else $error("busy not raised by compute");

  // The last result releases the block
  a_last_free: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> !busy_r)
    else $error("busy held after last result");

  // Results come only from a compute in progress
  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy_r))
    else $error("result strobe outside compute");

endmodule

// ===== rtl/core/mmt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mmt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/mmt_seq.sv =====
// Loop sequencer: walks row, column and inner index, one store read per cycle.
// Depends on mmt_pkg.
module mmt_seq (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       go,
  input  logic [mmt_pkg::IDX_W-1:0]  rows_last,
  input  logic [mmt_pkg::IDX_W-1:0]  cols_last,
  input  logic [mmt_pkg::IDX_W-1:0]  inner_last,
  input  logic [1:0]                 mode,
  output logic [mmt_pkg::ADDR_W-1:0] a_addr,
  output logic [mmt_pkg::ADDR_W-1:0] b_addr,
  output mmt_pkg::mmt_tag_t          tag
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic                      state_r, state_nxt;
  logic [mmt_pkg::IDX_W-1:0] i_r, i_nxt;
  logic [mmt_pkg::IDX_W-1:0] j_r, j_nxt;
  logic [mmt_pkg::IDX_W-1:0] k_r, k_nxt;
  logic                      k_end, j_end, i_end;

  assign k_end = (k_r == inner_last);
  assign j_end = (j_r == cols_last);
  assign i_end = (i_r == rows_last);

  // Counter advance: k fastest, then column, then row
  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    case (state_r)
      ST_IDLE: begin
        if (go) begin
          state_nxt = ST_RUN;
          i_nxt     = '0;
          j_nxt     = '0;
          k_nxt     = '0;
        end
      end
      ST_RUN: begin
        k_nxt = k_r + 1'b1;
        if (k_end) begin
          k_nxt = '0;
          j_nxt = j_r + 1'b1;
          if (j_end) begin
            j_nxt = '0;
            i_nxt = i_r + 1'b1;
            if (i_end) begin
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    i_r <= i_nxt;
    j_r <= j_nxt;
    k_r <= k_nxt;
  end

  // Store addresses as {row, col} for the selected product
  always_comb begin
    case (mode)
      mmt_pkg::MODE_ABT: begin
        a_addr = {i_r, k_r};
        b_addr = {j_r, k_r};
      end
      mmt_pkg::MODE_ATB: begin
        a_addr = {k_r, i_r};
        b_addr = {k_r, j_r};
      end
      default: begin
        a_addr = {i_r, k_r};
        b_addr = {k_r, j_r};
      end
    endcase
  end

  assign tag.vld       = (state_r == ST_RUN);
  assign tag.first     = (k_r == '0);
  assign tag.lastk     = k_end;
  assign tag.last_elem = i_end && j_end;
  assign tag.row       = i_r;
  assign tag.col       = j_r;

  // Counters stay inside the configured bounds while running
  a_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (k_r <= inner_last && j_r <= cols_last && i_r <= rows_last))
    else $error("sequencer index beyond dimension");

  // The final issue returns the sequencer to idle
  a_stop: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN && k_end && j_end && i_end) |=> (state_r == ST_IDLE))
    else $error("sequencer did not stop after last term");

  // A new run starts only from idle
  a_go_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && go) |=> (state_r == ST_RUN && k_r == '0 && i_r == '0))
    else $error("sequencer did not start cleanly");

endmodule

// ===== rtl/core/mmt_mac.sv =====
// Shared multiply-accumulate unit: product register, running sum, saturation.
// Depends on mmt_pkg.
module mmt_mac (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic signed [mmt_pkg::ELEM_W-1:0]  a_data,
  input  logic signed [mmt_pkg::ELEM_W-1:0]  b_data,
  input  mmt_pkg::mmt_tag_t                  tag_in,
  output logic                               done,
  output logic                               out_valid,
  output logic [mmt_pkg::IDX_W-1:0]          out_row,
  output logic [mmt_pkg::IDX_W-1:0]          out_col,
  output logic signed [mmt_pkg::OUT_W-1:0]   out_value,
  output logic                               out_last
);

  logic signed [mmt_pkg::PROD_W-1:0] prod_r;
  mmt_pkg::mmt_tag_t                 tag_r;
  logic signed [mmt_pkg::ACC_W-1:0]  acc_r, acc_nxt;
  logic signed [mmt_pkg::ACC_W-1:0]  prod_ext;
  logic                              fits;
  logic signed [mmt_pkg::OUT_W-1:0]  sat_val;
  logic                              out_valid_r;
  logic [mmt_pkg::IDX_W-1:0]         out_row_r, out_col_r;
  logic signed [mmt_pkg::OUT_W-1:0]  out_value_r;
  logic                              out_last_r;

  // Multiply stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= '0;
    end else begin
      tag_r <= tag_in;
    end
    prod_r <= a_data * b_data;
  end

  // Accumulate and saturate
  assign prod_ext = {{(mmt_pkg::ACC_W-mmt_pkg::PROD_W){prod_r[mmt_pkg::PROD_W-1]}}, prod_r};
  assign acc_nxt  = (tag_r.first ? '0 : acc_r) + prod_ext;
  assign fits     = (&acc_nxt[mmt_pkg::ACC_W-1:mmt_pkg::OUT_W-1]) ||
                    !(|acc_nxt[mmt_pkg::ACC_W-1:mmt_pkg::OUT_W-1]);
  assign sat_val  = fits ? acc_nxt[mmt_pkg::OUT_W-1:0] :
                    (acc_nxt[mmt_pkg::ACC_W-1] ? mmt_pkg::SAT_MIN : mmt_pkg::SAT_MAX);
  assign done     = tag_r.vld && tag_r.lastk && tag_r.last_elem;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= tag_r.vld && tag_r.lastk;
    end
    if (tag_r.vld) begin
      acc_r <= acc_nxt;
    end
    if (tag_r.vld && tag_r.lastk) begin
      out_row_r   <= tag_r.row;
      out_col_r   <= tag_r.col;
      out_value_r <= sat_val;
      out_last_r  <= tag_r.last_elem;
    end
  end

  assign out_valid = out_valid_r;
  assign out_row   = out_row_r;
  assign out_col   = out_col_r;
  assign out_value = out_value_r;
  assign out_last  = out_last_r;

  // A finished sum is always followed by its result strobe
  a_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (tag_r.vld && tag_r.lastk) |=> out_valid_r)
    else $error("result strobe missing");

  // Saturated value matches the sign of the exact sum
  a_sat_sign: assert property (@(posedge clk) disable iff (!rst_n)
    (tag_r.vld && !fits) |-> (sat_val[mmt_pkg::OUT_W-1] == acc_nxt[mmt_pkg::ACC_W-1]))
    else $error("saturation sign flipped");

  // Done marks the strobe of the last element
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> (out_valid_r && out_last_r))
    else $error("done without last result");

endmodule

// ===== tb/tb_matrix_multiply_transpose.sv =====
// Self-checking testbench for matrix_multiply_transpose: loads, products and config.
// Depends on mmt_pkg and the RTL; keeps its own copy of both stores to predict results.
`timescale 1ns / 100ps

module tb_matrix_multiply_transpose;
  import mmt_pkg::*;

  localparam int CLK_HALF       = 10;
  localparam int RESET_CYCLES   = 5;
  localparam int SETTLE_CYCLES  = 4;
  localparam int DRAIN_CYCLES   = 16;
  localparam int TIMEOUT_CYCLES = 500000;
  localparam int N_RANDOM       = 120;
  localparam int QUIET_TAIL     = 40;
  localparam int MAX_REPORTS    = 20;

  // Codes the package leaves out
  localparam logic [1:0] REQ_NONE  = 2'd3;
  localparam logic [1:0] MODE_RSVD = 2'd3;

  typedef struct {
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [OUT_W-1:0] value;
    logic                    last;
  } result_elem_t;

  // DUT connections
  logic                       clk;
  logic                       rst_n = 1'b0;
  logic                       start = 1'b0;
  logic                       busy;
  logic [1:0]                 in_req_type = REQ_WR_A;
  logic [IDX_W-1:0]           in_elem_row = '0;
  logic [IDX_W-1:0]           in_elem_col = '0;
  logic signed [ELEM_W-1:0]   in_elem_value = '0;
  logic                       out_valid;
  logic [IDX_W-1:0]           out_row;
  logic [IDX_W-1:0]           out_col;
  logic signed [OUT_W-1:0]    out_value;
  logic                       out_last;
  logic                       cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index = CFG_OUT_ROWS;
  logic [CFG_W-1:0]           cfg_wdata = '0;

  // Shadow state
  logic signed [ELEM_W-1:0] mat_a [MAX_DIM*MAX_DIM];
  logic signed [ELEM_W-1:0] mat_b [MAX_DIM*MAX_DIM];
  logic [DIM_W-1:0]         shadow_rows  = 4'd8;
  logic [DIM_W-1:0]         shadow_cols  = 4'd8;
  logic [DIM_W-1:0]         shadow_inner = 4'd8;
  logic [1:0]               shadow_mode  = MODE_AB;
  result_elem_t             pending_elems [$];

  int  err_count     = 0;
  int  elems_checked = 0;
  int  n_loads       = 0;
  int  n_computes    = 0;
  int  n_ignored     = 0;
  int  n_sat         = 0;
  int  cycle_count   = 0;
  bit  gap_enable    = 1'b0;

  matrix_multiply_transpose i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_req_type   (in_req_type),
    .in_elem_row   (in_elem_row),
    .in_elem_col   (in_elem_col),
    .in_elem_value (in_elem_value),
    .out_valid     (out_valid),
    .out_row       (out_row),
    .out_col       (out_col),
    .out_value     (out_value),
    .out_last      (out_last),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= TIMEOUT_CYCLES) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic void flag_error(input string msg);
    err_count++;
    if (err_count <= MAX_REPORTS) $display("%0t: %s", $time, msg);
  endfunction

  // Result checker: every strobe pops the oldest expected element
  always @(posedge clk) begin : check_results
    result_elem_t exp_e;
    if (rst_n && out_valid) begin
      if (pending_elems.size() == 0) begin
        flag_error($sformatf("unexpected result row %0d col %0d value %0d last %0b",
                             out_row, out_col, out_value, out_last));
      end else begin
        exp_e = pending_elems.pop_front();
        elems_checked++;
        if (out_row !== exp_e.row || out_col !== exp_e.col ||
            out_value !== exp_e.value || out_last !== exp_e.last) begin
          flag_error($sformatf({"mismatch: expected row %0d col %0d value %0d last %0b,",
                                " got row %0d col %0d value %0d last %0b"},
                               exp_e.row, exp_e.col, exp_e.value, exp_e.last,
                               out_row, out_col, out_value, out_last));
        end
      end
    end
  end

  // 0 acts as 1, above MAX_DIM as MAX_DIM
  function automatic int eff_dim(input logic [DIM_W-1:0] v);
    if (v == '0) return 1;
    if (v > DIM_W'(MAX_DIM)) return MAX_DIM;
    return int'(v);
  endfunction

  // Expected elements of one compute item, row-major
  function automatic void predict_product();
    int           rows;
    int           cols;
    int           inner;
    int           ia;
    int           ib;
    longint       sum;
    logic [1:0]   mode;
    result_elem_t e;
    rows  = eff_dim(shadow_rows);
    cols  = eff_dim(shadow_cols);
    inner = eff_dim(shadow_inner);
    mode  = (shadow_mode == MODE_RSVD) ? MODE_AB : shadow_mode;
    for (int i = 0; i < rows; i++) begin
      for (int j = 0; j < cols; j++) begin
        sum = 0;
        for (int k = 0; k < inner; k++) begin
          case (mode)
            MODE_ABT: begin
              ia = i * MAX_DIM + k;
              ib = j * MAX_DIM + k;
            end
            MODE_ATB: begin
              ia = k * MAX_DIM + i;
              ib = k * MAX_DIM + j;
            end
            default: begin
              ia = i * MAX_DIM + k;
              ib = k * MAX_DIM + j;
            end
          endcase
          sum += longint'(mat_a[ia]) * longint'(mat_b[ib]);
        end
        e.row  = IDX_W'(i);
        e.col  = IDX_W'(j);
        e.last = (i == rows - 1) && (j == cols - 1);
        if (sum > longint'(SAT_MAX)) begin
          e.value = SAT_MAX;
          n_sat++;
        end else if (sum < longint'(SAT_MIN)) begin
          e.value = SAT_MIN;
          n_sat++;
        end else begin
          e.value = sum[OUT_W-1:0];
        end
        pending_elems.push_back(e);
      end
    end
  endfunction

  // Send one item; start is left high so back-to-back items need no gap
  task automatic send_item(input logic [1:0] req, input logic [IDX_W-1:0] row,
                           input logic [IDX_W-1:0] col, input logic signed [ELEM_W-1:0] val);
    in_req_type   <= req;
    in_elem_row   <= row;
    in_elem_col   <= col;
    in_elem_value <= val;
    start         <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    case (req)
      REQ_WR_A: begin
        mat_a[{row, col}] = val;
        n_loads++;
      end
      REQ_WR_B: begin
        mat_b[{row, col}] = val;
        n_loads++;
      end
      REQ_COMPUTE: begin
        predict_product();
        n_computes++;
      end
      default: n_ignored++;
    endcase
    if (gap_enable && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  // Hold off until all results are in and the block has settled
  task automatic wait_idle();
    start <= 1'b0;
    while (pending_elems.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all four registers on consecutive cycles (block must be idle)
  task automatic set_config(input logic [DIM_W-1:0] rows, input logic [DIM_W-1:0] cols,
                            input logic [DIM_W-1:0] inner, input logic [1:0] mode);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_OUT_ROWS;
    cfg_wdata <= rows;
    @(posedge clk);
    cfg_index <= CFG_OUT_COLS;
    cfg_wdata <= cols;
    @(posedge clk);
    cfg_index <= CFG_INNER_LEN;
    cfg_wdata <= inner;
    @(posedge clk);
    cfg_index <= CFG_MODE;
    cfg_wdata <= CFG_W'(mode);
    @(posedge clk);
    cfg_we       <= 1'b0;
    shadow_rows  = rows;
    shadow_cols  = cols;
    shadow_inner = inner;
    shadow_mode  = mode;
  endtask

  function automatic logic signed [ELEM_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return 16'sh0000;
      3:       return -16'sh0001;
      default: return ELEM_W'($urandom);
    endcase
  endfunction

  // Mostly small dims, a few zero, full-size and out-of-range ones
  function automatic logic [DIM_W-1:0] pick_dim();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return DIM_W'($urandom_range(9, 15));
    if (r == 2) return DIM_W'(MAX_DIM);
    if (r <= 5) return DIM_W'($urandom_range(4, 7));
    return DIM_W'($urandom_range(1, 3));
  endfunction

  // Fill both stores, then one full 8x8x8 product with the reset settings
  task automatic test_reset_config();
    gap_enable = 1'b1;
    for (int idx = 0; idx < MAX_DIM * MAX_DIM; idx++) begin
      send_item(REQ_WR_A, IDX_W'(idx / MAX_DIM), IDX_W'(idx % MAX_DIM), pick_value());
      send_item(REQ_WR_B, IDX_W'(idx / MAX_DIM), IDX_W'(idx % MAX_DIM), pick_value());
    end
    send_item(REQ_COMPUTE, '0, '0, '0);
    gap_enable = 1'b0;
    wait_idle();
  endtask

  // Single products at the element extremes
  task automatic test_corner_products();
    set_config(4'd1, 4'd1, 4'd1, MODE_AB);
    send_item(REQ_WR_A, 3'd0, 3'd0, 16'sh7FFF);
    send_item(REQ_WR_B, 3'd0, 3'd0, 16'sh7FFF);
    send_item(REQ_COMPUTE, 3'd7, 3'd7, 16'sh7FFF);
    send_item(REQ_WR_B, 3'd0, 3'd0, 16'sh8000);
    send_item(REQ_COMPUTE, '0, '0, '0);
    send_item(REQ_WR_A, 3'd0, 3'd0, 16'sh8000);
    send_item(REQ_COMPUTE, '0, '0, '0);
    wait_idle();
  endtask

  // Type 3 must leave the stores alone
  task automatic test_ignored_request();
    send_item(REQ_NONE, 3'd0, 3'd0, 16'sh1234);
    send_item(REQ_NONE, 3'd7, 3'd7, -16'sh0001);
    send_item(REQ_COMPUTE, '0, '0, '0);
    wait_idle();
  endtask

  // Sums just past both ends of the 32-bit range
  task automatic test_saturation();
    set_config(4'd1, 4'd1, 4'd2, MODE_AB);
    send_item(REQ_WR_A, 3'd0, 3'd1, 16'sh8000);
    send_item(REQ_WR_B, 3'd1, 3'd0, 16'sh8000);
    send_item(REQ_COMPUTE, '0, '0, '0);
    wait_idle();
    set_config(4'd1, 4'd1, 4'd3, MODE_AB);
    send_item(REQ_WR_A, 3'd0, 3'd2, 16'sh8000);
    send_item(REQ_WR_B, 3'd0, 3'd0, 16'sh7FFF);
    send_item(REQ_WR_B, 3'd1, 3'd0, 16'sh7FFF);
    send_item(REQ_WR_B, 3'd2, 3'd0, 16'sh7FFF);
    send_item(REQ_COMPUTE, '0, '0, '0);
    wait_idle();
  endtask

  // Transposed modes, zero and oversize dims, reserved mode
  task automatic test_modes_and_dims();
    set_config(4'd2, 4'd3, 4'd2, MODE_ABT);
    send_item(REQ_COMPUTE, '0, '0, '0);
    wait_idle();
    set_config(4'd3, 4'd2, 4'd4, MODE_ATB);
    send_item(REQ_COMPUTE, '0, '0, '0);
    wait_idle();
    set_config(4'd0, 4'd0, 4'd0, MODE_ATB);
    send_item(REQ_COMPUTE, '0, '0, '0);
    wait_idle();
    set_config(4'd15, 4'd9, 4'd15, MODE_RSVD);
    send_item(REQ_COMPUTE, '0, '0, '0);
    wait_idle();
  endtask

  // Phases of random loads and computes under random settings
  task automatic test_random_traffic();
    int  sent;
    int  ops;
    int  r;
    bit  phase_gaps;
    sent = 0;
    while (sent < N_RANDOM) begin
      wait_idle();
      set_config(pick_dim(), pick_dim(), pick_dim(), 2'($urandom_range(0, 3)));
      phase_gaps = ($urandom_range(0, 2) != 0);
      ops = $urandom_range(1, 12);
      repeat (ops) begin
        gap_enable = phase_gaps && (N_RANDOM - sent > QUIET_TAIL);
        r = $urandom_range(0, 15);
        if (r == 0) begin
          send_item(REQ_NONE, IDX_W'($urandom), IDX_W'($urandom), ELEM_W'($urandom));
        end else if (r < 3) begin
          send_item(REQ_COMPUTE, IDX_W'($urandom), IDX_W'($urandom), ELEM_W'($urandom));
          sent++;
        end else begin
          send_item(r[0] ? REQ_WR_A : REQ_WR_B, IDX_W'($urandom), IDX_W'($urandom),
                    pick_value());
          sent++;
        end
      end
      gap_enable = phase_gaps && (N_RANDOM - sent > QUIET_TAIL);
      send_item(REQ_COMPUTE, IDX_W'($urandom), IDX_W'($urandom), ELEM_W'($urandom));
      sent++;
    end
    gap_enable = 1'b0;
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_config();
    test_corner_products();
    test_ignored_request();
    test_saturation();
    test_modes_and_dims();
    test_random_traffic();

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Run covered %0d loads, %0d computes, %0d ignored requests, %0d elements checked",
             n_loads, n_computes, n_ignored, elems_checked);
    $display("in all modes incl. reserved, clamped dims and %0d saturated sums.", n_sat);
    if (err_count == 0 && pending_elems.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/mmt_pkg.sv
rtl/core/mmt_ram.sv
rtl/core/mmt_seq.sv
rtl/core/mmt_mac.sv
rtl/core/matrix_multiply_transpose.sv
tb/tb_matrix_multiply_transpose.sv
